FILE: design/bsm_pkg.sv
// Shared types and constants for the bank switch mapper with scanline interrupt.
// Holds the request and result structs, the controller/datapath link and the codes.
// Has no dependencies; every other design file imports it.
package bsm_pkg;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] address;
		logic [7:0]  data;
	} bsm_req_t;

	typedef struct packed {
		logic        handled;
		logic [21:0] mapped_address;
		logic        vertical_mirroring;
		logic        irq_request;
	} bsm_rsp_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic commit;
	} bsm_cmd_t;

	typedef struct packed {
		logic need_div;
	} bsm_sts_t;

	localparam logic [2:0] MODE_CPU_READ  = 3'd0;
	localparam logic [2:0] MODE_CPU_WRITE = 3'd1;
	localparam logic [2:0] MODE_PPU_MAP   = 3'd2;
	localparam logic [2:0] MODE_TICK      = 3'd3;
	localparam logic [2:0] MODE_IRQ_ACK   = 3'd4;

	localparam logic [1:0] REG_BANK      = 2'd0;
	localparam logic [1:0] REG_MIRROR    = 2'd1;
	localparam logic [1:0] REG_IRQ_LATCH = 2'd2;
	localparam logic [1:0] REG_IRQ_CTRL  = 2'd3;

	localparam logic [7:0] PRG_COUNT_RESET = 8'd16;
	localparam int         DIV_STEPS       = 4;

endpackage

FILE: design/bsm_ctrl.sv
// Controller state machine for the bank switch mapper.
// Sequences accept, the bank modulo steps and the result commit; depends on bsm_pkg.
module bsm_ctrl import bsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_stall,
	input  bsm_sts_t sts,
	output logic     in_stall,
	output logic     out_valid,
	output bsm_cmd_t cmd
);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

	state_t     state_q;
	logic [1:0] step_q;
	logic       out_valid_q;
	logic       out_free;

	always_comb begin
		out_free     = !out_valid_q || !out_stall;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.div_step = (state_q == S_DIV);
		cmd.commit   = (state_q == S_DONE) && out_free;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= sts.need_div ? S_DIV : S_DONE;
						step_q  <= '0;
					end
				end
				S_DIV: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/bsm_datapath.sv
// Datapath of the bank switch mapper: mapper registers, address translation,
// the two-bit-per-cycle bank modulo unit and the result register; depends on bsm_pkg.
module bsm_datapath import bsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bsm_cmd_t   cmd,
	output bsm_sts_t   sts,
	input  bsm_req_t   in_req,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data,
	output bsm_rsp_t   out_rsp
);

	logic [7:0] prg_count_q;
	logic [7:0] bank_select_q;
	logic [7:0] bank_q [8];
	logic       mirror_q;
	logic [7:0] reload_val_q;
	logic [7:0] count_q;
	logic       reload_flag_q;
	logic       irq_en_q;
	logic       irq_flag_q;

	bsm_req_t   req_q;
	logic [7:0] dvd_q;
	logic [8:0] rem_q;
	bsm_rsp_t   rsp_q;

	logic [8:0] total;
	logic [8:0] rem_next;
	logic [9:0] trial;

	logic [7:0] bank_select_n;
	logic       mirror_n;
	logic [7:0] reload_val_n;
	logic [7:0] count_n;
	logic       reload_flag_n;
	logic       irq_en_n;
	logic       irq_flag_n;
	logic       bank_we;

	logic        handled;
	logic [21:0] mapped;
	logic [8:0]  prg_bank;
	logic [2:0]  chr_win;
	logic [2:0]  chr_idx;
	logic [7:0]  chr_val;
	logic [7:0]  chr_bank;

	function automatic logic is_reg_window(logic [1:0] win, logic swap);
		return (win == 2'd1) || ((win == 2'd0) && !swap) || ((win == 2'd2) && swap);
	endfunction

	assign total = {prg_count_q, 1'b0};

	assign sts.need_div = (in_req.mode == MODE_CPU_READ) && in_req.address[15]
		&& (prg_count_q != 8'd0)
		&& is_reg_window(in_req.address[14:13], bank_select_q[6]);

	always_comb begin
		rem_next = rem_q;
		trial    = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_next, dvd_q[7 - k]};
			if (trial >= {1'b0, total}) begin
				trial = trial - {1'b0, total};
			end
			rem_next = trial[8:0];
		end
	end

	always_comb begin
		bank_select_n = bank_select_q;
		mirror_n      = mirror_q;
		reload_val_n  = reload_val_q;
		count_n       = count_q;
		reload_flag_n = reload_flag_q;
		irq_en_n      = irq_en_q;
		irq_flag_n    = irq_flag_q;
		bank_we       = 1'b0;
		case (req_q.mode)
			MODE_CPU_WRITE: begin
				if (req_q.address[15]) begin
					case (req_q.address[14:13])
						REG_BANK: begin
							if (!req_q.address[0]) begin
								bank_select_n = req_q.data;
							end else begin
								bank_we = 1'b1;
							end
						end
						REG_MIRROR: begin
							if (!req_q.address[0]) begin
								mirror_n = req_q.data[0];
							end
						end
						REG_IRQ_LATCH: begin
							if (!req_q.address[0]) begin
								reload_val_n = req_q.data;
							end else begin
								count_n       = 8'd0;
								reload_flag_n = 1'b1;
							end
						end
						REG_IRQ_CTRL: begin
							if (!req_q.address[0]) begin
								irq_en_n   = 1'b0;
								irq_flag_n = 1'b0;
							end else begin
								irq_en_n = 1'b1;
							end
						end
						default: begin
							bank_we = 1'b0;
						end
					endcase
				end
			end
			MODE_TICK: begin
				if ((count_q == 8'd0) || reload_flag_q) begin
					count_n       = reload_val_q;
					reload_flag_n = 1'b0;
				end else begin
					count_n = count_q - 8'd1;
				end
				if ((count_n == 8'd0) && irq_en_q) begin
					irq_flag_n = 1'b1;
				end
			end
			MODE_IRQ_ACK: begin
				irq_flag_n = 1'b0;
			end
			default: begin
				bank_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		handled  = 1'b0;
		mapped   = '0;
		prg_bank = '0;
		chr_win  = req_q.address[12:10] ^ {bank_select_q[7], 2'b00};
		chr_idx  = chr_win[2] ? (3'd2 + {1'b0, chr_win[1:0]}) : {2'b00, chr_win[1]};
		chr_val  = bank_q[chr_idx];
		chr_bank = chr_win[2] ? chr_val : {chr_val[7:1], chr_win[0]};
		case (req_q.mode)
			MODE_CPU_READ: begin
				if (req_q.address[15]) begin
					handled = 1'b1;
					if (is_reg_window(req_q.address[14:13], bank_select_q[6])) begin
						prg_bank = rem_q;
					end else if (req_q.address[14:13] == 2'd3) begin
						prg_bank = total - 9'd1;
					end else begin
						prg_bank = total - 9'd2;
					end
					if (prg_count_q == 8'd0) begin
						mapped = {9'd0, req_q.address[12:0]};
					end else begin
						mapped = {prg_bank, req_q.address[12:0]};
					end
				end
			end
			MODE_PPU_MAP: begin
				if (req_q.address[15:13] == 3'd0) begin
					handled = 1'b1;
					mapped  = {4'd0, chr_bank, req_q.address[9:0]};
				end
			end
			default: begin
				handled = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q   <= PRG_COUNT_RESET;
			bank_select_q <= '0;
			for (int i = 0; i < 8; i++) begin
				bank_q[i] <= '0;
			end
			mirror_q      <= 1'b0;
			reload_val_q  <= '0;
			count_q       <= '0;
			reload_flag_q <= 1'b0;
			irq_en_q      <= 1'b0;
			irq_flag_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				prg_count_q <= cfg_write_data;
			end
			if (cmd.commit) begin
				bank_select_q <= bank_select_n;
				mirror_q      <= mirror_n;
				reload_val_q  <= reload_val_n;
				count_q       <= count_n;
				reload_flag_q <= reload_flag_n;
				irq_en_q      <= irq_en_n;
				irq_flag_q    <= irq_flag_n;
				if (bank_we) begin
					bank_q[bank_select_q[2:0]] <= req_q.data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_req;
			rem_q <= '0;
			dvd_q <= (in_req.address[14:13] == 2'd1) ? bank_q[7] : bank_q[6];
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[5:0], 2'b00};
		end
		if (cmd.commit) begin
			rsp_q <= {handled, mapped, !mirror_n, irq_flag_n};
		end
	end

	assign out_rsp = rsp_q;

endmodule

FILE: design/bank_switch_mapper_scanline_irq_core.sv
// Top level of the bank switch mapper with scanline interrupt counter.
// Joins the controller bsm_ctrl and the datapath bsm_datapath; depends on bsm_pkg.
//
// Each request on the input channel is one bus event: a CPU read to translate,
// a CPU write to the mapper registers, a PPU pattern fetch to translate, a
// scanline tick or an interrupt acknowledge. Every request gives exactly one
// result with the hit flag, the translated address, the mirroring and the
// interrupt flag as they stand after the request.
// A request is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// One request is worked on at a time; each is accepted and committed to the
// output register before the next accept. A CPU read of a register-selected
// program window first runs its bank number through the modulo unit, which
// retires two remainder bits per cycle, when the bank count is nonzero.
// The result sits in an output register, so the next request is accepted
// while the receiver stalls; that request then waits in its final state
// until the output register frees.
// Reset clears all mapper registers and the interrupt counter and sets the
// program bank count to 16. The user must write the bank count through
// cfg_write_en/cfg_write_data only while no request is in flight (not enforced).
module bank_switch_mapper_scanline_irq_core import bsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  bsm_req_t   in_req,
	output logic       out_valid,
	input  logic       out_stall,
	output bsm_rsp_t   out_rsp,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data
);

	bsm_cmd_t cmd;
	bsm_sts_t sts;

	bsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	bsm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_req         (in_req),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.out_rsp        (out_rsp)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Block accepted a request while another was in flight.");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("Committed result did not appear on the output.");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rsp.handled |-> out_rsp.mapped_address == '0)
		else $error("Unhandled result carries a nonzero address.");

endmodule
